FILE: design/dqvl_pkg.sv
// shared types, register indexes and sine helper for the dq voltage limit inverse park unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dqvl_pkg;

    // default sine table depth, entries per electrical turn (power of two)
    localparam int SINE_DEPTH_DEF = 1024;

    // sqrt and divider sizes
    localparam int ROOT_W = 24;
    localparam int QUO_W  = 16;
    localparam int NUM_W  = 39;

    // configuration register indexes
    localparam logic [2:0] REG_BUS_VOLTAGE = 3'd0;
    localparam logic [2:0] REG_MAX_PHASE   = 3'd1;
    localparam logic [2:0] REG_MAX_DUTY    = 3'd2;
    localparam logic [2:0] REG_ZERO_CLAMP  = 3'd3;
    localparam logic [2:0] REG_ZERO_ON     = 3'd4;

    // reset values
    localparam logic [14:0] BUS_VOLTAGE_RST = 15'd12000;
    localparam logic [14:0] MAX_PHASE_RST   = 15'd6000;
    localparam logic [15:0] MAX_DUTY_RST    = 16'd62259;
    localparam logic [14:0] ZERO_CLAMP_RST  = 15'd100;
    localparam logic        ZERO_ON_RST     = 1'b1;

    // polynomial coefficients in Q28
    localparam logic [63:0] C1_Q28 = 64'd421657428;
    localparam logic [63:0] C3_Q28 = 64'd173399667;
    localparam logic [63:0] C5_Q28 = 64'd21392326;
    localparam logic [63:0] C7_Q28 = 64'd1256748;
    localparam logic [63:0] C9_Q28 = 64'd43069;

    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic [15:0]        elec_angle;
        logic               direct_mode;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] alpha_mv;
        logic signed [15:0] beta_mv;
        logic [14:0]        command_mv;
        logic signed [15:0] applied_d;
        logic signed [15:0] applied_q;
        logic [15:0]        angle_out;
        logic               zero_vector;
        logic               was_limited;
        logic               direct_out;
    } res_t;

    // fields carried alongside the square root
    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic [15:0]        angle;
        logic               direct;
        logic signed [16:0] sin_v;
        logic signed [16:0] cos_v;
        logic [14:0]        lim;
        logic               limited;
        logic [30:0]        pa_d;
        logic [30:0]        pa_q;
    } sq_side_t;

    // fields carried alongside the divider
    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic [15:0]        angle;
        logic               direct;
        logic signed [16:0] sin_v;
        logic signed [16:0] cos_v;
        logic [14:0]        lim;
        logic               limited;
        logic [ROOT_W-1:0]  root;
    } div_side_t;

    // quarter-wave sine, r in 0..16384, q15 result 0..32768
    function automatic logic [15:0] quarter_sin(input logic [14:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        x  = {49'd0, r} << 14;
        x2 = (x * x) >> 28;
        p  = C9_Q28;
        p  = C7_Q28 - ((p * x2) >> 28);
        p  = C5_Q28 - ((p * x2) >> 28);
        p  = C3_Q28 - ((p * x2) >> 28);
        p  = C1_Q28 - ((p * x2) >> 28);
        p  = (p * x) >> 28;
        p  = (p + 64'd4096) >> 13;
        return p[15:0];
    endfunction

    // shift right by 15 rounding half away from zero, saturate to 16 bits
    function automatic logic signed [15:0] round_sat15(input logic signed [33:0] v);
        logic        neg;
        logic [33:0] mag;
        logic [33:0] r;
        logic signed [15:0] res;
        neg = v[33];
        mag = neg ? 34'(-v) : 34'(v);
        r   = (mag + 34'd16384) >> 15;
        if (!neg)
        begin
            res = (r > 34'd32767) ? 16'sd32767 : 16'(r);
        end
        else
        begin
            res = (r > 34'd32768) ? -16'sd32768 : 16'(-r);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/dqvl_sqrt.sv
// pipelined integer square root, one result bit per stage, with sideband
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module dqvl_sqrt #(
    parameter int ROOT_W = 24,
    parameter int SB_W   = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [2*ROOT_W-1:0]   rad,
    input  wire logic [SB_W-1:0]       sb_in,
    output logic                       out_vld,
    output logic [ROOT_W-1:0]          root,
    output logic [SB_W-1:0]            sb_out
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SB_W-1:0]   sb_reg   [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SB_W-1:0]   sbi;
        logic              v_in;
        logic [REM_W-1:0]  r2;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sbi     = sb_in;
            assign v_in    = in_vld;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign sbi     = sb_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        // bring down two bits and try the next root bit
        assign r2    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= rad_in << 2;
                rem_reg[i]  <= ge ? (r2 - trial) : r2;
                root_reg[i] <= {root_in[ROOT_W-2:0], ge};
                sb_reg[i]   <= sbi;
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];
    assign sb_out  = sb_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: design/dqvl_div.sv
// pipelined restoring divider, two numerators over one divisor, one quotient bit per stage
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module dqvl_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 24,
    parameter int QUO_W = 16,
    parameter int SB_W  = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num_a,
    input  wire logic [NUM_W-1:0]  num_b,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SB_W-1:0]   sb_in,
    output logic                   out_vld,
    output logic [QUO_W-1:0]       quo_a,
    output logic [QUO_W-1:0]       quo_b,
    output logic [SB_W-1:0]        sb_out
);
    logic [NUM_W-1:0] na_reg  [QUO_W];
    logic [NUM_W-1:0] nb_reg  [QUO_W];
    logic [QUO_W-1:0] qa_reg  [QUO_W];
    logic [QUO_W-1:0] qb_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [SB_W-1:0]  sb_reg  [QUO_W];
    logic [QUO_W-1:0] vld_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic [NUM_W-1:0] na_in;
        logic [NUM_W-1:0] nb_in;
        logic [QUO_W-1:0] qa_in;
        logic [QUO_W-1:0] qb_in;
        logic [DEN_W-1:0] den_in;
        logic [SB_W-1:0]  sbi;
        logic             v_in;
        logic [NUM_W-1:0] dsh;
        logic             ge_a;
        logic             ge_b;

        if (i == 0)
        begin : g_first
            assign na_in  = num_a;
            assign nb_in  = num_b;
            assign qa_in  = '0;
            assign qb_in  = '0;
            assign den_in = den;
            assign sbi    = sb_in;
            assign v_in   = in_vld;
        end
        else
        begin : g_next
            assign na_in  = na_reg[i-1];
            assign nb_in  = nb_reg[i-1];
            assign qa_in  = qa_reg[i-1];
            assign qb_in  = qb_reg[i-1];
            assign den_in = den_reg[i-1];
            assign sbi    = sb_reg[i-1];
            assign v_in   = vld_reg[i-1];
        end

        // divisor aligned to this quotient bit
        assign dsh  = NUM_W'(den_in) << (QUO_W - 1 - i);
        assign ge_a = (na_in >= dsh);
        assign ge_b = (nb_in >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                na_reg[i]  <= ge_a ? (na_in - dsh) : na_in;
                nb_reg[i]  <= ge_b ? (nb_in - dsh) : nb_in;
                qa_reg[i]  <= {qa_in[QUO_W-2:0], ge_a};
                qb_reg[i]  <= {qb_in[QUO_W-2:0], ge_b};
                den_reg[i] <= den_in;
                sb_reg[i]  <= sbi;
            end
        end
    end

    assign out_vld = vld_reg[QUO_W-1];
    assign quo_a   = qa_reg[QUO_W-1];
    assign quo_b   = qb_reg[QUO_W-1];
    assign sb_out  = sb_reg[QUO_W-1];

endmodule

`default_nettype wire

FILE: design/dq_voltage_limit_inverse_park_unit.sv
// top level: dq voltage limit and inverse park transform with sine table
// depends on dqvl_pkg, dqvl_sqrt and dqvl_div
// request accept to result valid passes 45 register stages: 2 setup
// stages, 24 sqrt stages, 16 divider stages, then select, multiply and round stages
// throughput one request per cycle; the whole pipeline holds while the result is stalled
// sine table depth must be a power of two; configuration registers reset to defaults
// reset clears all valid bits asynchronously, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module dq_voltage_limit_inverse_park_unit
    import dqvl_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_t             res,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int LOG_D  = $clog2(SINE_TABLE_DEPTH);
    localparam int SHIFT  = 16 - LOG_D;
    localparam int J_W    = LOG_D - 2;
    localparam int QN     = SINE_TABLE_DEPTH / 4 + 1;
    localparam int IDX_W  = LOG_D - 1;
    localparam logic [IDX_W-1:0] QUARTER = IDX_W'(SINE_TABLE_DEPTH / 4);

    // configuration registers
    logic [14:0] bus_reg;
    logic [14:0] maxph_reg;
    logic [15:0] duty_reg;
    logic [14:0] zclamp_reg;
    logic        zon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg    <= BUS_VOLTAGE_RST;
            maxph_reg  <= MAX_PHASE_RST;
            duty_reg   <= MAX_DUTY_RST;
            zclamp_reg <= ZERO_CLAMP_RST;
            zon_reg    <= ZERO_ON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUS_VOLTAGE: bus_reg    <= cfg_data[14:0];
                REG_MAX_PHASE:   maxph_reg  <= cfg_data[14:0];
                REG_MAX_DUTY:    duty_reg   <= cfg_data;
                REG_ZERO_CLAMP:  zclamp_reg <= cfg_data[14:0];
                REG_ZERO_ON:     zon_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless the result is held
    logic adv;
    assign adv       = !(res_valid && res_stall);
    assign cmd_stall = !adv;

    // quarter-wave sine table, built at elaboration
    logic [15:0] qtab [QN];
    for (genvar i = 0; i < QN; i++)
    begin : g_tab
        assign qtab[i] = quarter_sin(15'(i << SHIFT));
    end

    // sine and cosine lookup from the request angle
    logic [1:0]         qd;
    logic [1:0]         qc;
    logic [J_W-1:0]     jj;
    logic [IDX_W-1:0]   sidx;
    logic [IDX_W-1:0]   cidx;
    logic [15:0]        smag;
    logic [15:0]        cmag;
    logic signed [16:0] sin_c;
    logic signed [16:0] cos_c;

    always_comb
    begin
        qd    = cmd.elec_angle[15:14];
        qc    = qd + 2'd1;
        jj    = cmd.elec_angle[13 -: J_W];
        sidx  = qd[0] ? (QUARTER - {1'b0, jj}) : {1'b0, jj};
        cidx  = qc[0] ? (QUARTER - {1'b0, jj}) : {1'b0, jj};
        smag  = qtab[sidx];
        cmag  = qtab[cidx];
        sin_c = qd[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        cos_c = qc[1] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end

    // stage 1: squares, magnitudes, duty bound product
    logic               s1_vld_reg;
    cmd_t               s1_cmd_reg;
    logic signed [16:0] s1_sin_reg;
    logic signed [16:0] s1_cos_reg;
    logic [15:0]        s1_ad_reg;
    logic [15:0]        s1_aq_reg;
    logic [31:0]        s1_sqd_reg;
    logic [31:0]        s1_sqq_reg;
    logic [14:0]        s1_lim_reg;
    logic [30:0]        s1_dprod_reg;

    logic [15:0] ad_next;
    logic [15:0] aq_next;
    logic [15:0] dfac;

    always_comb
    begin
        ad_next = cmd.volt_d[15] ? 16'(-cmd.volt_d) : 16'(cmd.volt_d);
        aq_next = cmd.volt_q[15] ? 16'(-cmd.volt_q) : 16'(cmd.volt_q);
        dfac    = duty_reg[15] ? {duty_reg[14:0], 1'b0} : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg   <= cmd;
            s1_sin_reg   <= sin_c;
            s1_cos_reg   <= cos_c;
            s1_ad_reg    <= ad_next;
            s1_aq_reg    <= aq_next;
            s1_sqd_reg   <= ad_next * ad_next;
            s1_sqq_reg   <= aq_next * aq_next;
            s1_lim_reg   <= (maxph_reg < bus_reg) ? maxph_reg : bus_reg;
            s1_dprod_reg <= bus_reg * dfac;
        end
    end

    // stage 2: magnitude squared, final limit, scaled numerators
    logic               s2_vld_reg;
    cmd_t               s2_cmd_reg;
    logic signed [16:0] s2_sin_reg;
    logic signed [16:0] s2_cos_reg;
    logic [31:0]        s2_m2_reg;
    logic [14:0]        s2_lim_reg;
    logic [30:0]        s2_pad_reg;
    logic [30:0]        s2_paq_reg;
    logic [29:0]        s2_llsq_reg;

    logic [14:0] dl;
    logic [14:0] lim_next;

    always_comb
    begin
        dl       = s1_dprod_reg[30:16];
        lim_next = (s1_lim_reg > dl) ? dl : s1_lim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_sin_reg  <= s1_sin_reg;
            s2_cos_reg  <= s1_cos_reg;
            s2_m2_reg   <= s1_sqd_reg + s1_sqq_reg;
            s2_lim_reg  <= lim_next;
            s2_pad_reg  <= s1_ad_reg * lim_next;
            s2_paq_reg  <= s1_aq_reg * lim_next;
            s2_llsq_reg <= lim_next * lim_next;
        end
    end

    // square root of the magnitude squared in q8
    sq_side_t sq_in;
    sq_side_t sq_out;
    logic     sq_vld;
    logic [ROOT_W-1:0] sq_root;

    always_comb
    begin
        sq_in.volt_d  = s2_cmd_reg.volt_d;
        sq_in.volt_q  = s2_cmd_reg.volt_q;
        sq_in.angle   = s2_cmd_reg.elec_angle;
        sq_in.direct  = s2_cmd_reg.direct_mode;
        sq_in.sin_v   = s2_sin_reg;
        sq_in.cos_v   = s2_cos_reg;
        sq_in.lim     = s2_lim_reg;
        sq_in.limited = (s2_m2_reg > {2'b00, s2_llsq_reg});
        sq_in.pa_d    = s2_pad_reg;
        sq_in.pa_q    = s2_paq_reg;
    end

    dqvl_sqrt #(
        .ROOT_W (ROOT_W),
        .SB_W   ($bits(sq_side_t))
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s2_vld_reg),
        .rad     ({s2_m2_reg, 16'd0}),
        .sb_in   (sq_in),
        .out_vld (sq_vld),
        .root    (sq_root),
        .sb_out  (sq_out)
    );

    // scale both components by limit over magnitude
    div_side_t dv_in;
    div_side_t dv_out;
    logic      dv_vld;
    logic [QUO_W-1:0] quo_d;
    logic [QUO_W-1:0] quo_q;

    always_comb
    begin
        dv_in.volt_d  = sq_out.volt_d;
        dv_in.volt_q  = sq_out.volt_q;
        dv_in.angle   = sq_out.angle;
        dv_in.direct  = sq_out.direct;
        dv_in.sin_v   = sq_out.sin_v;
        dv_in.cos_v   = sq_out.cos_v;
        dv_in.lim     = sq_out.lim;
        dv_in.limited = sq_out.limited;
        dv_in.root    = sq_root;
    end

    dqvl_div #(
        .NUM_W (NUM_W),
        .DEN_W (ROOT_W),
        .QUO_W (QUO_W),
        .SB_W  ($bits(div_side_t))
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (sq_vld),
        .num_a   ({sq_out.pa_d, 8'd0}),
        .num_b   ({sq_out.pa_q, 8'd0}),
        .den     (sq_root),
        .sb_in   (dv_in),
        .out_vld (dv_vld),
        .quo_a   (quo_d),
        .quo_b   (quo_q),
        .sb_out  (dv_out)
    );

    // stage a: applied components, command and zero flag
    logic               a_vld_reg;
    logic signed [15:0] a_d_reg;
    logic signed [15:0] a_q_reg;
    logic [14:0]        a_cmd_reg;
    logic               a_zero_reg;
    logic               a_lim_reg;
    logic [15:0]        a_ang_reg;
    logic               a_dir_reg;
    logic signed [16:0] a_sin_reg;
    logic signed [16:0] a_cos_reg;

    logic signed [15:0] ad_sel;
    logic signed [15:0] aq_sel;
    logic [14:0]        cmd_sel;

    always_comb
    begin
        if (dv_out.limited)
        begin
            ad_sel  = dv_out.volt_d[15] ? 16'(-quo_d) : 16'(quo_d);
            aq_sel  = dv_out.volt_q[15] ? 16'(-quo_q) : 16'(quo_q);
            cmd_sel = dv_out.lim;
        end
        else
        begin
            ad_sel  = dv_out.volt_d;
            aq_sel  = dv_out.volt_q;
            cmd_sel = dv_out.root[22:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg    <= ad_sel;
            a_q_reg    <= aq_sel;
            a_cmd_reg  <= cmd_sel;
            a_zero_reg <= zon_reg && (cmd_sel < zclamp_reg);
            a_lim_reg  <= dv_out.limited;
            a_ang_reg  <= dv_out.angle;
            a_dir_reg  <= dv_out.direct;
            a_sin_reg  <= dv_out.sin_v;
            a_cos_reg  <= dv_out.cos_v;
        end
    end

    // stage b: inverse park products
    logic               b_vld_reg;
    logic signed [32:0] b_dc_reg;
    logic signed [32:0] b_qs_reg;
    logic signed [32:0] b_ds_reg;
    logic signed [32:0] b_qc_reg;
    logic signed [15:0] b_d_reg;
    logic signed [15:0] b_q_reg;
    logic [14:0]        b_cmd_reg;
    logic               b_zero_reg;
    logic               b_lim_reg;
    logic [15:0]        b_ang_reg;
    logic               b_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_dc_reg   <= a_d_reg * a_cos_reg;
            b_qs_reg   <= a_q_reg * a_sin_reg;
            b_ds_reg   <= a_d_reg * a_sin_reg;
            b_qc_reg   <= a_q_reg * a_cos_reg;
            b_d_reg    <= a_d_reg;
            b_q_reg    <= a_q_reg;
            b_cmd_reg  <= a_cmd_reg;
            b_zero_reg <= a_zero_reg;
            b_lim_reg  <= a_lim_reg;
            b_ang_reg  <= a_ang_reg;
            b_dir_reg  <= a_dir_reg;
        end
    end

    // output stage: sums, rounding and saturation
    logic signed [33:0] alpha_sum;
    logic signed [33:0] beta_sum;
    res_t               res_next;
    res_t               res_reg;
    logic               res_valid_reg;

    always_comb
    begin
        alpha_sum            = 34'(b_dc_reg) - 34'(b_qs_reg);
        beta_sum             = 34'(b_ds_reg) + 34'(b_qc_reg);
        res_next.alpha_mv    = round_sat15(alpha_sum);
        res_next.beta_mv     = round_sat15(beta_sum);
        res_next.command_mv  = b_cmd_reg;
        res_next.applied_d   = b_d_reg;
        res_next.applied_q   = b_q_reg;
        res_next.angle_out   = b_ang_reg;
        res_next.zero_vector = b_zero_reg;
        res_next.was_limited = b_lim_reg;
        res_next.direct_out  = b_dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: dv/dq_voltage_limit_inverse_park_unit_tb.sv
// testbench for the dq voltage limit inverse park unit: directed and random requests,
// predicted results compared as a whole against the block output
// depends on dqvl_pkg and the dq_voltage_limit_inverse_park_unit rtl
`timescale 1ns / 1ps

module dq_voltage_limit_inverse_park_unit_tb;
    import dqvl_pkg::*;

    localparam int DEPTH = 1024;
    localparam int LATENCY = 45;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_t        cmd;
    logic        res_valid;
    logic        res_stall;
    res_t        res;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // testbench copy of the registers
    logic [14:0] bus_mv;
    logic [14:0] phase_mv;
    logic [15:0] duty_q16;
    logic [14:0] clamp_mv;
    logic        clamp_on;

    cmd_t   pending_cmds[$];
    res_t   expected_res[$];
    int     mismatches;
    int     send_idle_pct;
    int     stall_pct;
    bit     hold_off;
    int     hold_count;
    longint cycles;

    dq_voltage_limit_inverse_park_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // quarter wave sine polynomial in q28, q15 result
    function automatic longint quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        x  = r << 14;
        x2 = (x * x) >> 28;
        p  = 43069;
        p  = 64'd1256748 - ((p * x2) >> 28);
        p  = 64'd21392326 - ((p * x2) >> 28);
        p  = 64'd173399667 - ((p * x2) >> 28);
        p  = 64'd421657428 - ((p * x2) >> 28);
        p  = (p * x) >> 28;
        return longint'((p + 4096) >> 13);
    endfunction

    function automatic longint table_sine(input logic [15:0] ph);
        logic [1:0] quad;
        longint s;
        quad = ph[15:14];
        s = quad[0] ? quarter_sine(16384 - ph[13:0]) : quarter_sine(ph[13:0]);
        return quad[1] ? -s : s;
    endfunction

    function automatic logic signed [15:0] rotate_round(input longint v);
        longint r;
        r = (v >= 0) ? ((v + 16384) >>> 15) : -((-v + 16384) >>> 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic longint shrink_comp(input longint v, input longint lim,
                                           input longint m8);
        longint a;
        a = (v < 0) ? -v : v;
        a = (a * lim * 256) / m8;
        return (v < 0) ? -a : a;
    endfunction

    function automatic res_t predict_voltage(input cmd_t c);
        res_t   r;
        longint d;
        longint q;
        longint ad;
        longint aq;
        longint lim;
        longint duty_lim;
        longint twice;
        longint mag2;
        longint cmd_v;
        longint m8;
        longint sn;
        longint cs;
        longint k;
        logic [15:0] ph;
        d = c.volt_d;
        q = c.volt_q;
        ad = d;
        aq = q;
        r = '0;
        lim = (phase_mv < bus_mv) ? phase_mv : bus_mv;
        twice = 2 * longint'(duty_q16);
        duty_lim = (twice > 65536) ? ((longint'(bus_mv) * (twice - 65536)) >>> 16) : 0;
        if (lim > duty_lim) lim = duty_lim;
        mag2 = d * d + q * q;
        if (mag2 > lim * lim)
        begin
            m8 = longint'(int_sqrt(mag2 << 16));
            ad = shrink_comp(d, lim, m8);
            aq = shrink_comp(q, lim, m8);
            cmd_v = lim;
            r.was_limited = 1'b1;
        end
        else
            cmd_v = longint'(int_sqrt(mag2));
        k = (longint'(c.elec_angle) * DEPTH) >>> 16;
        ph = 16'((k << 16) / DEPTH);
        sn = table_sine(ph);
        cs = table_sine(ph + 16'd16384);
        r.alpha_mv    = rotate_round(ad * cs - aq * sn);
        r.beta_mv     = rotate_round(ad * sn + aq * cs);
        r.command_mv  = 15'(cmd_v);
        r.applied_d   = 16'(ad);
        r.applied_q   = 16'(aq);
        r.angle_out   = c.elec_angle;
        r.zero_vector = clamp_on && (cmd_v < clamp_mv);
        r.direct_out  = c.direct_mode;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
                expected_res.push_back(predict_voltage(cmd));
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd <= pending_cmds.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_count <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_res.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", res);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (res !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, res);
                    end
                end
            end
            if (hold_off)
            begin
                res_stall <= (hold_count < 300);
                hold_count <= hold_count + 1;
            end
            else
            begin
                hold_count <= 0;
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** dq_voltage_limit_inverse_park_unit: FAILED **");
            $finish;
        end
    end

    task automatic drain_results();
        while (pending_cmds.size() > 0 || cmd_valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one write, then the enable is dropped before returning so back to back writes never collide on the enable
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BUS_VOLTAGE: bus_mv = val[14:0];
            REG_MAX_PHASE:   phase_mv = val[14:0];
            REG_MAX_DUTY:    duty_q16 = val;
            REG_ZERO_CLAMP:  clamp_mv = val[14:0];
            REG_ZERO_ON:     clamp_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int bus, input int ph, input int duty,
                            input int clamp, input int on);
        write_reg(REG_BUS_VOLTAGE, 16'(bus));
        write_reg(REG_MAX_PHASE, 16'(ph));
        write_reg(REG_MAX_DUTY, 16'(duty));
        write_reg(REG_ZERO_CLAMP, 16'(clamp));
        write_reg(REG_ZERO_ON, 16'(on));
    endtask

    task automatic add_cmd(input int d, input int q, input int ang, input bit dir);
        cmd_t c;
        c.volt_d = 16'(d);
        c.volt_q = 16'(q);
        c.elec_angle = 16'(ang);
        c.direct_mode = dir;
        pending_cmds.push_back(c);
    endtask

    // random request: a mix of moderate vectors near the limit, small vectors and full range vectors
    task automatic add_random(input int n);
        int sel;
        int d;
        int q;
        repeat (n)
        begin
            sel = $urandom_range(9);
            if (sel < 4)
            begin
                d = $urandom_range(16000) - 8000;
                q = $urandom_range(16000) - 8000;
            end
            else if (sel < 6)
            begin
                d = $urandom_range(400) - 200;
                q = $urandom_range(400) - 200;
            end
            else
            begin
                d = $urandom_range(65535) - 32768;
                q = $urandom_range(65535) - 32768;
            end
            add_cmd(d, q, $urandom_range(65535), $urandom_range(1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        bus_mv = BUS_VOLTAGE_RST;
        phase_mv = MAX_PHASE_RST;
        duty_q16 = MAX_DUTY_RST;
        clamp_mv = ZERO_CLAMP_RST;
        clamp_on = ZERO_ON_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, zero vector, limiting, angles at quadrant edges
        add_cmd(0, 0, 0, 0);
        add_cmd(32767, 32767, 65535, 1);
        add_cmd(-32768, -32768, 16384, 0);
        add_cmd(-32768, 32767, 32768, 1);
        add_cmd(32767, -32768, 49152, 0);
        add_cmd(50, 30, 63, 1);
        add_cmd(99, 0, 64, 0);
        add_cmd(100, 0, 8192, 1);
        add_cmd(3000, 4000, 12345, 0);
        add_cmd(-6000, 0, 40000, 1);
        add_cmd(0, -6001, 21845, 0);
        add_cmd(1, -1, 65472, 1);
        drain_results();

        // zero limit via low duty, then full registers with clamp off
        set_regs(32767, 32767, 32768, 32767, 1);
        add_cmd(5, 5, 1000, 0);
        add_cmd(-32768, 32767, 30000, 1);
        add_cmd(0, 0, 65535, 0);
        drain_results();
        set_regs(32767, 32767, 65535, 0, 0);
        add_cmd(32767, 32767, 8000, 1);
        add_cmd(-32768, -32768, 24000, 0);
        add_cmd(20000, -20000, 60000, 1);
        add_cmd(0, 0, 0, 0);
        drain_results();
        write_reg(3'd7, 16'hffff);

        // random phases over several register settings and idle patterns
        set_regs(12000, 6000, 62259, 100, 1);
        add_random(280);
        drain_results();

        set_regs(24000, 32767, 50000, 2000, 1);
        send_idle_pct = 86;
        add_random(240);
        drain_results();

        set_regs(0, 0, 0, 0, 1);
        send_idle_pct = 0;
        stall_pct = 86;
        add_random(100);
        drain_results();

        set_regs(32767, 10000, 40000, 32767, 1);
        add_random(180);
        send_idle_pct = 19;
        stall_pct = 19;
        drain_results();

        // long receiver hold-off while the sender keeps offering
        set_regs(16000, 9000, 60000, 500, 0);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        add_random(150);
        while (hold_count < 300) @(posedge clk);
        hold_off = 1'b0;
        drain_results();

        set_regs(20000, 15000, 65535, 300, 1);
        add_random(150);
        drain_results();

        if (mismatches == 0 && expected_res.size() == 0)
            $display("** dq_voltage_limit_inverse_park_unit: PASSED **");
        else
            $display("** dq_voltage_limit_inverse_park_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
design/dqvl_pkg.sv
design/dqvl_sqrt.sv
design/dqvl_div.sv
design/dq_voltage_limit_inverse_park_unit.sv
dv/dq_voltage_limit_inverse_park_unit_tb.sv
